>>> src/heip_pkg.sv
// Shared types, constants and helpers for the hex-framed Ethernet/IPv4/ICMP header parser.
package heip_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned OutDataW = 232;

  localparam logic [CfgIdxW-1:0] CFG_TERMINATOR = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ETHERTYPE  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_ICMP_PROTO = 2'd2;

  localparam logic [7:0]  TERM_RESET      = 8'd37;
  localparam logic [15:0] ETHERTYPE_RESET = 16'h0800;
  localparam logic [7:0]  ICMP_PROTO_RESET = 8'd1;

  localparam logic [7:0] CHARS_MAX  = 8'd255;
  localparam logic [6:0] BYTE_LIMIT = 7'd80;
  localparam logic [6:0] ETH_HDR_BYTES = 7'd14;
  localparam logic [6:0] IP_MIN_END   = 7'd34;
  localparam logic [6:0] ICMP_HDR_BYTES = 7'd4;

  typedef enum logic [3:0] {
    ST_SHORT       = 4'd0,
    ST_NO_TERM     = 4'd1,
    ST_ODD         = 4'd2,
    ST_BAD_HEX     = 4'd3,
    ST_ETH_SHORT   = 4'd4,
    ST_NOT_IPV4    = 4'd5,
    ST_IP_SHORT    = 4'd6,
    ST_IHL_SHORT   = 4'd7,
    ST_NON_ICMP_OK = 4'd8,
    ST_ICMP_SHORT  = 4'd9,
    ST_ICMP_OK     = 4'd10
  } status_e;

  typedef struct packed {
    logic [7:0]  terminator_char;
    logic [15:0] accepted_ethertype;
    logic [7:0]  icmp_protocol_number;
  } heip_cfg_t;

  typedef struct packed {
    status_e     status;
    logic [47:0] dst_mac;
    logic [47:0] src_mac;
    logic [15:0] ether_type;
    logic [3:0]  ip_version;
    logic [5:0]  ip_header_bytes;
    logic [7:0]  ip_protocol;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [7:0]  icmp_type;
    logic [7:0]  icmp_code;
    logic [15:0] icmp_checksum;
  } heip_result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } nibble_t;

  function automatic nibble_t hex_decode(input logic [7:0] c);
    nibble_t r;
    r.ok    = 1'b1;
    r.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.value = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.value = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.value = 4'(c - 8'h37);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

>>> src/hex_framed_eth_ipv4_icmp_header_parser_top.sv
// Top level of the hex-framed Ethernet/IPv4/ICMP header parser.
//
//  channel   | direction | handshake                    | payload
//  ----------+-----------+------------------------------+-------------------------------
//  s_axis    | in        | s_axis_tvalid/s_axis_tready  | tdata char_in, tlast frame_end
//  m_axis    | out       | m_axis_tvalid/m_axis_tready  | tuser status, tdata header fields
//  cfg       | in        | cfg_valid_i/cfg_ready_o      | cfg_index_i, cfg_data_i
//
// One word per cycle is accepted unless a stalled result blocks the held terminator word;
// a result is valid in the cycle after its terminator word is taken, via the result register.
// Reset clears frame state, valid flags and restores the register defaults.
// A stalled result holds the next terminator word in the input register, which stalls the input.
module hex_framed_eth_ipv4_icmp_header_parser_top import heip_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,  // [7:0] char_in
  input  logic                s_axis_tlast,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [47:0] dst_mac, [95:48] src_mac, [111:96] ether_type, [115:112] ip_version,
  // [121:116] ip_header_bytes, [129:122] ip_protocol, [161:130] src_ip,
  // [193:162] dst_ip, [201:194] icmp_type, [209:202] icmp_code,
  // [225:210] icmp_checksum, [231:226] zero
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic [3:0]          m_axis_tuser,  // [3:0] status
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  heip_cfg_t    cfg_q, cfg_d;
  logic         in_valid;
  logic [7:0]   in_char;
  logic         in_last;
  logic         take;
  logic         res_valid;
  logic         out_free;
  heip_result_t res;
  heip_result_t out_res;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_TERMINATOR: cfg_d.terminator_char      = cfg_data_i[7:0];
        CFG_ETHERTYPE:  cfg_d.accepted_ethertype   = cfg_data_i;
        CFG_ICMP_PROTO: cfg_d.icmp_protocol_number = cfg_data_i[7:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.terminator_char      <= TERM_RESET;
      cfg_q.accepted_ethertype   <= ETHERTYPE_RESET;
      cfg_q.icmp_protocol_number <= ICMP_PROTO_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  heip_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_char_i  (s_axis_tdata),
    .s_last_i  (s_axis_tlast),
    .take_i    (take),
    .valid_o   (in_valid),
    .char_o    (in_char),
    .last_o    (in_last)
  );

  heip_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .valid_i     (in_valid),
    .char_i      (in_char),
    .last_i      (in_last),
    .out_free_i  (out_free),
    .take_o      (take),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  heip_out_stage u_out_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (res_valid),
    .res_i     (res),
    .free_o    (out_free),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .res_o     (out_res)
  );

  assign m_axis_tuser = out_res.status;
  assign m_axis_tdata = {6'd0,
                         out_res.icmp_checksum,
                         out_res.icmp_code,
                         out_res.icmp_type,
                         out_res.dst_ip,
                         out_res.src_ip,
                         out_res.ip_protocol,
                         out_res.ip_header_bytes,
                         out_res.ip_version,
                         out_res.ether_type,
                         out_res.src_mac,
                         out_res.dst_mac};

endmodule

>>> src/heip_in_stage.sv
// Input register for received characters, loaded when empty or when the parser takes the held word.
module heip_in_stage import heip_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_valid_i,
  output logic       s_ready_o,
  input  logic [7:0] s_char_i,
  input  logic       s_last_i,
  input  logic       take_i,
  output logic       valid_o,
  output logic [7:0] char_o,
  output logic       last_o
);

  logic       valid_q, valid_d;
  logic [7:0] char_q;
  logic       last_q;
  logic       load;

  assign s_ready_o = !valid_q || take_i;
  assign load      = s_valid_i && s_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= s_char_i;
      last_q <= s_last_i;
    end
  end

  assign valid_o = valid_q;
  assign char_o  = char_q;
  assign last_o  = last_q;

endmodule

>>> src/heip_parser.sv
// Frame state, hex decode, header field capture and status evaluation.
module heip_parser import heip_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  heip_cfg_t    cfg_i,
  input  logic         valid_i,
  input  logic [7:0]   char_i,
  input  logic         last_i,
  input  logic         out_free_i,
  output logic         take_o,
  output logic         res_valid_o,
  output heip_result_t res_o
);

  logic [7:0]  chars_seen_q, chars_seen_d;
  logic        parity_q, parity_d;
  logic [3:0]  pending_q, pending_d;
  logic        bad_hex_q, bad_hex_d;
  logic [47:0] dst_mac_q, dst_mac_d;
  logic [47:0] src_mac_q, src_mac_d;
  logic [15:0] ether_type_q, ether_type_d;
  logic [7:0]  ver_ihl_q, ver_ihl_d;
  logic [7:0]  protocol_q, protocol_d;
  logic [31:0] src_ip_q, src_ip_d;
  logic [31:0] dst_ip_q, dst_ip_d;
  logic [31:0] icmp_word_q, icmp_word_d;

  nibble_t     nib;
  logic [3:0]  nval;
  logic [7:0]  byte_val;
  logic [6:0]  byte_idx;
  logic        capture;
  logic [3:0]  ihl_src;
  logic [6:0]  icmp_off;
  logic [7:0]  len;
  logic [6:0]  blen;
  logic [5:0]  hb;
  status_e     status;

  assign take_o      = valid_i && (!last_i || out_free_i);
  assign res_valid_o = take_o && last_i;

  assign nib      = hex_decode(char_i);
  assign nval     = nib.ok ? nib.value : 4'd0;
  assign byte_val = {pending_q, nval};
  assign byte_idx = chars_seen_q[7:1] - 7'd1;
  assign capture  = (chars_seen_q != 8'd0) && !parity_q && (chars_seen_q != CHARS_MAX)
                    && (byte_idx < BYTE_LIMIT);
  assign ihl_src  = (byte_idx == ETH_HDR_BYTES) ? byte_val[3:0] : ver_ihl_q[3:0];
  assign icmp_off = ETH_HDR_BYTES + {1'b0, ihl_src, 2'b00};

  always_comb begin
    chars_seen_d = chars_seen_q;
    parity_d     = parity_q;
    pending_d    = pending_q;
    bad_hex_d    = bad_hex_q;
    dst_mac_d    = dst_mac_q;
    src_mac_d    = src_mac_q;
    ether_type_d = ether_type_q;
    ver_ihl_d    = ver_ihl_q;
    protocol_d   = protocol_q;
    src_ip_d     = src_ip_q;
    dst_ip_d     = dst_ip_q;
    icmp_word_d  = icmp_word_q;
    if (take_o) begin
      if (last_i) begin
        chars_seen_d = 8'd0;
        parity_d     = 1'b0;
        pending_d    = 4'd0;
        bad_hex_d    = 1'b0;
        dst_mac_d    = '0;
        src_mac_d    = '0;
        ether_type_d = '0;
        ver_ihl_d    = '0;
        protocol_d   = '0;
        src_ip_d     = '0;
        dst_ip_d     = '0;
        icmp_word_d  = '0;
      end else begin
        if (chars_seen_q != 8'd0) begin
          if (!nib.ok) begin
            bad_hex_d = 1'b1;
          end
          if (parity_q) begin
            pending_d = nval;
          end else if (capture) begin
            if (byte_idx < 7'd6) begin
              dst_mac_d = {dst_mac_q[39:0], byte_val};
            end else if (byte_idx < 7'd12) begin
              src_mac_d = {src_mac_q[39:0], byte_val};
            end else if (byte_idx < ETH_HDR_BYTES) begin
              ether_type_d = {ether_type_q[7:0], byte_val};
            end else if (byte_idx == ETH_HDR_BYTES) begin
              ver_ihl_d = byte_val;
            end else if (byte_idx == 7'd23) begin
              protocol_d = byte_val;
            end else if (byte_idx >= 7'd26 && byte_idx < 7'd30) begin
              src_ip_d = {src_ip_q[23:0], byte_val};
            end else if (byte_idx >= 7'd30 && byte_idx < IP_MIN_END) begin
              dst_ip_d = {dst_ip_q[23:0], byte_val};
            end
            if (byte_idx >= ETH_HDR_BYTES && byte_idx >= icmp_off
                && byte_idx < icmp_off + ICMP_HDR_BYTES) begin
              icmp_word_d = {icmp_word_q[23:0], byte_val};
            end
          end
        end
        if (chars_seen_q != CHARS_MAX) begin
          chars_seen_d = chars_seen_q + 8'd1;
        end
        parity_d = !parity_q;
      end
    end
  end

  assign len  = (chars_seen_q == CHARS_MAX) ? CHARS_MAX : chars_seen_q + 8'd1;
  assign blen = 7'((len - 8'd2) >> 1);
  assign hb   = {ver_ihl_q[3:0], 2'b00};

  always_comb begin
    if (len < 8'd4) begin
      status = ST_SHORT;
    end else if (char_i != cfg_i.terminator_char) begin
      status = ST_NO_TERM;
    end else if (!parity_q) begin
      status = ST_ODD;
    end else if (bad_hex_q) begin
      status = ST_BAD_HEX;
    end else if (blen < ETH_HDR_BYTES) begin
      status = ST_ETH_SHORT;
    end else if (ether_type_q != cfg_i.accepted_ethertype) begin
      status = ST_NOT_IPV4;
    end else if (blen < IP_MIN_END) begin
      status = ST_IP_SHORT;
    end else if (blen < ETH_HDR_BYTES + {1'b0, hb}) begin
      status = ST_IHL_SHORT;
    end else if (protocol_q != cfg_i.icmp_protocol_number) begin
      status = ST_NON_ICMP_OK;
    end else if (blen < ETH_HDR_BYTES + ICMP_HDR_BYTES + {1'b0, hb}) begin
      status = ST_ICMP_SHORT;
    end else begin
      status = ST_ICMP_OK;
    end
  end

  always_comb begin
    res_o        = '0;
    res_o.status = status;
    if (status >= ST_NOT_IPV4) begin
      res_o.dst_mac    = dst_mac_q;
      res_o.src_mac    = src_mac_q;
      res_o.ether_type = ether_type_q;
    end
    if (status >= ST_NON_ICMP_OK) begin
      res_o.ip_version      = ver_ihl_q[7:4];
      res_o.ip_header_bytes = hb;
      res_o.ip_protocol     = protocol_q;
      res_o.src_ip          = src_ip_q;
      res_o.dst_ip          = dst_ip_q;
    end
    if (status == ST_ICMP_OK) begin
      res_o.icmp_type     = icmp_word_q[31:24];
      res_o.icmp_code     = icmp_word_q[23:16];
      res_o.icmp_checksum = icmp_word_q[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chars_seen_q <= 8'd0;
      parity_q     <= 1'b0;
      pending_q    <= 4'd0;
      bad_hex_q    <= 1'b0;
      dst_mac_q    <= '0;
      src_mac_q    <= '0;
      ether_type_q <= '0;
      ver_ihl_q    <= '0;
      protocol_q   <= '0;
      src_ip_q     <= '0;
      dst_ip_q     <= '0;
      icmp_word_q  <= '0;
    end else begin
      chars_seen_q <= chars_seen_d;
      parity_q     <= parity_d;
      pending_q    <= pending_d;
      bad_hex_q    <= bad_hex_d;
      dst_mac_q    <= dst_mac_d;
      src_mac_q    <= src_mac_d;
      ether_type_q <= ether_type_d;
      ver_ihl_q    <= ver_ihl_d;
      protocol_q   <= protocol_d;
      src_ip_q     <= src_ip_d;
      dst_ip_q     <= dst_ip_d;
      icmp_word_q  <= icmp_word_d;
    end
  end

endmodule

>>> src/heip_out_stage.sv
// Result register holding one frame result until the downstream side takes it.
module heip_out_stage import heip_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         load_i,
  input  heip_result_t res_i,
  output logic         free_o,
  output logic         m_valid_o,
  input  logic         m_ready_i,
  output heip_result_t res_o
);

  logic         valid_q, valid_d;
  heip_result_t res_q;

  assign free_o = !valid_q || m_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign m_valid_o = valid_q;
  assign res_o     = res_q;

endmodule
